>>> rtl/polyline_stroke_to_triangles_top_defines.svh
// Assertion macros shared by the stroke-to-triangles RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POLYLINE_STROKE_TO_TRIANGLES_TOP_DEFINES_SVH
`define POLYLINE_STROKE_TO_TRIANGLES_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pst_pkg.sv
// Package for the polyline stroke block: widths, register indexes, types.
// No dependencies; used by pst_iter and the top level.
package pst_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SAT_W      = 2 * COORD_BITS + 2;

    typedef enum logic [2:0] {
        REG_COEF_XX      = 3'd0,
        REG_COEF_XY      = 3'd1,
        REG_COEF_YX      = 3'd2,
        REG_COEF_YY      = 3'd3,
        REG_SHIFT_X      = 3'd4,
        REG_SHIFT_Y      = 3'd5,
        REG_STROKE_WIDTH = 3'd6,
        REG_STROKE_COLOR = 3'd7
    } reg_idx_t;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctl_t;

    // Clamp a wide signed value to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            sat_coord = $signed(hi[COORD_BITS-1:0]);
        end
        else if (v < lo)
        begin
            sat_coord = $signed(lo[COORD_BITS-1:0]);
        end
        else
        begin
            sat_coord = $signed(v[COORD_BITS-1:0]);
        end
    endfunction

endpackage

>>> rtl/pst_iter.sv
// Shared bit-serial unit: 64-bit floor square root or 64/32 division.
// Depends on pst_pkg. One result bit per cycle.
module pst_iter
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iter_ctl_t   ctl,
    input  logic [63:0] opa,
    input  logic [31:0] opb,
    output logic        busy,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    iter_op_t    op_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [31:0] rem_reg;
    logic [31:0] d_reg;

    logic [32:0] div_shift;
    logic [63:0] sub_a, sub_b;
    logic [64:0] diff;
    logic        ge;

    // One subtractor serves both operations.
    always_comb
    begin
        div_shift = {rem_reg, v_reg[63]};
        if (op_reg == OP_SQRT)
        begin
            sub_a = v_reg;
            sub_b = r_reg + bit_reg;
        end
        else
        begin
            sub_a = {31'd0, div_shift};
            sub_b = {32'd0, d_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[64];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg == 5'd31)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (ctl.start)
            begin
                cnt_reg <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg <= ctl.op;
            r_reg  <= 64'd0;
            d_reg  <= opb;
            if (ctl.op == OP_SQRT)
            begin
                v_reg   <= opa;
                bit_reg <= 64'd1 << 62;
                rem_reg <= 32'd0;
            end
            else
            begin
                v_reg   <= {opa[31:0], 32'd0};
                bit_reg <= 64'd0;
                rem_reg <= opa[63:32];
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                if (ge)
                begin
                    v_reg <= diff[63:0];
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                rem_reg <= ge ? diff[31:0] : div_shift[31:0];
                v_reg   <= v_reg << 1;
                r_reg   <= {r_reg[62:0], ge};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = r_reg[31:0];

endmodule

>>> rtl/polyline_stroke_to_triangles_top.sv
// Top level of the polyline stroke to triangle lowering block.
// Depends on pst_pkg, pst_iter and polyline_stroke_to_triangles_top_defines.svh.
`include "polyline_stroke_to_triangles_top_defines.svh"
// Usage:
// Path points enter on the point channel (valid/ready); a transaction carries
// point_x, point_y, last_point and close_path. Each point is transformed by
// the affine registers set over the APB port. Every nonzero segment between
// consecutive points leaves on the vertex channel as six vertex transactions
// (two triangles), and end_of_run marks the last vertex caused by a point.
// A path of a single point gives one transaction with status set.
// The block works on one point at a time and drops point_ready meanwhile.
// Each accepted point is transformed first. A segment then passes through a
// test for zero length, normalization, the squares, the square root, the
// two divides and the vertices, in that order; the shared 32-step root and
// divide unit does most of the work. A point that closes a path can cost two
// segments. The vertex output is registered: a stalled receiver holds the
// current vertex and the sequencer waits, and the next point may be taken
// while the final vertex still waits. Reset restores the register defaults,
// clears the path state and empties the output.
module polyline_stroke_to_triangles_top
    import pst_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         point_valid,
    output logic                         point_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    input  logic                         close_path,
    output logic                         vertex_valid,
    input  logic                         vertex_ready,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output logic [31:0]                  vertex_color,
    output logic                         end_of_run,
    output logic                         status
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_XFORM  = 11'b00000000010,
        ST_DECIDE = 11'b00000000100,
        ST_STATUS = 11'b00000001000,
        ST_SEG    = 11'b00000010000,
        ST_NORM   = 11'b00000100000,
        ST_SQ     = 11'b00001000000,
        ST_SQRT   = 11'b00010000000,
        ST_NUM    = 11'b00100000000,
        ST_DIV    = 11'b01000000000,
        ST_EMIT   = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [2:0] k_reg;
    logic [2:0] vidx_reg;
    logic       phase_reg;

    // Configuration registers.
    logic signed [31:0] coef_xx_reg, coef_xy_reg, coef_yx_reg, coef_yy_reg;
    logic signed [31:0] shift_x_reg, shift_y_reg;
    logic [30:0]        stroke_width_reg;
    logic [31:0]        stroke_color_reg;

    // Captured point.
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic                         last_reg, close_reg;

    // Datapath.
    logic signed [65:0]           prod_reg;
    logic signed [64:0]           acc_reg;
    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;
    logic signed [COORD_BITS-1:0] first_tx_reg, first_ty_reg, prev_tx_reg, prev_ty_reg;
    logic                         started_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic                         close_pend_reg;
    logic [32:0]                  mx_reg, my_reg;
    logic                         dx_neg_reg, dy_pos_reg;
    logic [31:0]                  len_reg, nxm_reg, nym_reg;

    // Output register.
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [31:0]                  out_color_reg;
    logic                         out_eor_reg, out_status_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [SAT_W-1:0] fin_sum;
    logic signed [31:0] fin_shift;
    logic signed [32:0] dx, dy;
    logic [32:0]        big;
    logic signed [32:0] nx, ny;
    logic signed [COORD_BITS-1:0] px, py, vx, vy;
    logic               plus_side, use_a;
    logic               can_load;
    logic               out_load;
    logic [32:0]        hw;

    iter_ctl_t   iter_ctl;
    logic [63:0] iter_opa;
    logic        iter_busy, iter_done;
    logic [31:0] iter_result;

    logic cfg_write;
    assign cfg_write   = psel && penable && pwrite;
    assign pready      = 1'b1;
    assign point_ready = (state_reg == ST_IDLE);
    assign can_load    = !out_valid_reg || vertex_ready;
    // A new transaction enters the output register in this cycle.
    assign out_load    = can_load && (state_reg == ST_EMIT || state_reg == ST_STATUS);
    assign hw          = {3'd0, stroke_width_reg[30:1]};

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_COEF_XX:      prdata = coef_xx_reg;
            REG_COEF_XY:      prdata = coef_xy_reg;
            REG_COEF_YX:      prdata = coef_yx_reg;
            REG_COEF_YY:      prdata = coef_yy_reg;
            REG_SHIFT_X:      prdata = shift_x_reg;
            REG_SHIFT_Y:      prdata = shift_y_reg;
            REG_STROKE_WIDTH: prdata = {1'b0, stroke_width_reg};
            REG_STROKE_COLOR: prdata = stroke_color_reg;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg      <= 32'sd65536;
            coef_xy_reg      <= 32'sd0;
            coef_yx_reg      <= 32'sd0;
            coef_yy_reg      <= 32'sd65536;
            shift_x_reg      <= 32'sd0;
            shift_y_reg      <= 32'sd0;
            stroke_width_reg <= 31'd65536;
            stroke_color_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_COEF_XX:      coef_xx_reg      <= pwdata;
                REG_COEF_XY:      coef_xy_reg      <= pwdata;
                REG_COEF_YX:      coef_yx_reg      <= pwdata;
                REG_COEF_YY:      coef_yy_reg      <= pwdata;
                REG_SHIFT_X:      shift_x_reg      <= pwdata;
                REG_SHIFT_Y:      shift_y_reg      <= pwdata;
                REG_STROKE_WIDTH: stroke_width_reg <= pwdata[30:0];
                REG_STROKE_COLOR: stroke_color_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    // Operand select for the single shared multiplier.
    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            ST_XFORM:
            begin
                case (k_reg)
                    3'd0:    begin mul_a = 33'(coef_xx_reg); mul_b = 33'(pt_x_reg); end
                    3'd1:    begin mul_a = 33'(coef_xy_reg); mul_b = 33'(pt_y_reg); end
                    3'd2:    begin mul_a = 33'(coef_yx_reg); mul_b = 33'(pt_x_reg); end
                    3'd3:    begin mul_a = 33'(coef_yy_reg); mul_b = 33'(pt_y_reg); end
                    default: ;
                endcase
            end
            ST_SQ:
            begin
                if (k_reg == 3'd0)
                begin
                    mul_a = $signed({2'b00, mx_reg[30:0]});
                    mul_b = $signed({2'b00, mx_reg[30:0]});
                end
                else
                begin
                    mul_a = $signed({2'b00, my_reg[30:0]});
                    mul_b = $signed({2'b00, my_reg[30:0]});
                end
            end
            ST_NUM:
            begin
                mul_a = phase_reg ? $signed({2'b00, mx_reg[30:0]})
                                  : $signed({2'b00, my_reg[30:0]});
                mul_b = $signed(hw);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Finish of one transform coordinate: floor shift, translate, clamp.
    always_comb
    begin
        fin_shift = (k_reg == 3'd3) ? shift_x_reg : shift_y_reg;
        fin_sum   = SAT_W'(acc_reg >>> FRAC_BITS) + SAT_W'(fin_shift);
    end

    always_comb
    begin
        dx  = 33'(bx_reg) - 33'(ax_reg);
        dy  = 33'(by_reg) - 33'(ay_reg);
        big = (mx_reg > my_reg) ? mx_reg : my_reg;
        nx  = dy_pos_reg ? -$signed({1'b0, nxm_reg}) : $signed({1'b0, nxm_reg});
        ny  = dx_neg_reg ? -$signed({1'b0, nym_reg}) : $signed({1'b0, nym_reg});
        // Quad order: A-n, B-n, B+n, A-n, B+n, A+n.
        use_a     = (vidx_reg == 3'd0) || (vidx_reg == 3'd3) || (vidx_reg == 3'd5);
        plus_side = (vidx_reg == 3'd2) || (vidx_reg == 3'd4) || (vidx_reg == 3'd5);
        px = use_a ? ax_reg : bx_reg;
        py = use_a ? ay_reg : by_reg;
        if (plus_side)
        begin
            vx = sat_coord(SAT_W'(px) + SAT_W'(nx));
            vy = sat_coord(SAT_W'(py) + SAT_W'(ny));
        end
        else
        begin
            vx = sat_coord(SAT_W'(px) - SAT_W'(nx));
            vy = sat_coord(SAT_W'(py) - SAT_W'(ny));
        end
    end

    always_comb
    begin
        iter_ctl.start = 1'b0;
        iter_ctl.op    = OP_SQRT;
        iter_opa       = acc_reg[63:0];
        if (state_reg == ST_SQ && k_reg == 3'd3)
        begin
            iter_ctl.start = 1'b1;
        end
        else if (state_reg == ST_NUM && k_reg == 3'd1)
        begin
            iter_ctl.start = 1'b1;
            iter_ctl.op    = OP_DIV;
            iter_opa       = prod_reg[63:0] + {33'd0, len_reg[31:1]};
        end
    end

    pst_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iter_ctl),
        .opa    (iter_opa),
        .opb    (len_reg),
        .busy   (iter_busy),
        .done   (iter_done),
        .result (iter_result)
    );

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= 3'd0;
            vidx_reg       <= 3'd0;
            phase_reg      <= 1'b0;
            started_reg    <= 1'b0;
            close_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_tx_reg   <= '0;
            first_ty_reg   <= '0;
            prev_tx_reg    <= '0;
            prev_ty_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vertex_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (point_valid)
                    begin
                        k_reg     <= 3'd0;
                        state_reg <= ST_XFORM;
                    end
                end
                ST_XFORM:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd5)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (!started_reg)
                    begin
                        first_tx_reg <= tx_reg;
                        first_ty_reg <= ty_reg;
                        prev_tx_reg  <= tx_reg;
                        prev_ty_reg  <= ty_reg;
                        if (last_reg)
                        begin
                            state_reg <= ST_STATUS;
                        end
                        else
                        begin
                            started_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        prev_tx_reg    <= tx_reg;
                        prev_ty_reg    <= ty_reg;
                        started_reg    <= !last_reg;
                        close_pend_reg <= last_reg && close_reg &&
                                          (tx_reg != first_tx_reg || ty_reg != first_ty_reg);
                        state_reg      <= ST_SEG;
                    end
                end
                ST_STATUS:
                begin
                    if (can_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SEG:
                begin
                    if (dx == 33'sd0 && dy == 33'sd0)
                    begin
                        close_pend_reg <= 1'b0;
                        state_reg      <= close_pend_reg ? ST_SEG : ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (big[32:31] == 2'b00 && big[30])
                    begin
                        k_reg     <= 3'd0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd3)
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (iter_done)
                    begin
                        k_reg     <= 3'd0;
                        phase_reg <= 1'b0;
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd1)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (iter_done)
                    begin
                        k_reg <= 3'd0;
                        if (!phase_reg)
                        begin
                            phase_reg <= 1'b1;
                            state_reg <= ST_NUM;
                        end
                        else
                        begin
                            vidx_reg  <= 3'd0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        vidx_reg <= vidx_reg + 3'd1;
                        if (vidx_reg == 3'd5)
                        begin
                            close_pend_reg <= 1'b0;
                            state_reg      <= close_pend_reg ? ST_SEG : ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (point_valid && point_ready)
        begin
            pt_x_reg  <= point_x;
            pt_y_reg  <= point_y;
            last_reg  <= last_point;
            close_reg <= close_path;
        end
        case (state_reg)
            ST_XFORM:
            begin
                case (k_reg)
                    3'd1:    acc_reg <= 65'(prod_reg);
                    3'd2:    acc_reg <= acc_reg + 65'(prod_reg);
                    3'd3:
                    begin
                        tx_reg  <= sat_coord(fin_sum);
                        acc_reg <= 65'(prod_reg);
                    end
                    3'd4:    acc_reg <= acc_reg + 65'(prod_reg);
                    3'd5:    ty_reg  <= sat_coord(fin_sum);
                    default: ;
                endcase
            end
            ST_DECIDE:
            begin
                ax_reg <= prev_tx_reg;
                ay_reg <= prev_ty_reg;
                bx_reg <= tx_reg;
                by_reg <= ty_reg;
            end
            ST_STATUS:
            begin
                if (can_load)
                begin
                    out_x_reg      <= '0;
                    out_y_reg      <= '0;
                    out_color_reg  <= 32'd0;
                    out_eor_reg    <= 1'b1;
                    out_status_reg <= 1'b1;
                end
            end
            ST_SEG:
            begin
                if (dx == 33'sd0 && dy == 33'sd0)
                begin
                    ax_reg <= bx_reg;
                    ay_reg <= by_reg;
                    bx_reg <= first_tx_reg;
                    by_reg <= first_ty_reg;
                end
                else
                begin
                    mx_reg     <= dx[32] ? 33'(-dx) : 33'(dx);
                    my_reg     <= dy[32] ? 33'(-dy) : 33'(dy);
                    dx_neg_reg <= dx[32];
                    dy_pos_reg <= !dy[32] && (dy != 33'sd0);
                end
            end
            ST_NORM:
            begin
                if (big[32:31] != 2'b00)
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end
                else if (!big[30])
                begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                end
            end
            ST_SQ:
            begin
                if (k_reg == 3'd1)
                begin
                    acc_reg <= 65'(prod_reg);
                end
                else if (k_reg == 3'd2)
                begin
                    acc_reg <= acc_reg + 65'(prod_reg);
                end
            end
            ST_SQRT:
            begin
                if (iter_done)
                begin
                    len_reg <= iter_result;
                end
            end
            ST_DIV:
            begin
                if (iter_done)
                begin
                    if (!phase_reg)
                    begin
                        nxm_reg <= iter_result;
                    end
                    else
                    begin
                        nym_reg <= iter_result;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_x_reg      <= vx;
                    out_y_reg      <= vy;
                    out_color_reg  <= stroke_color_reg;
                    out_eor_reg    <= (vidx_reg == 3'd5) && !close_pend_reg;
                    out_status_reg <= 1'b0;
                    if (vidx_reg == 3'd5 && close_pend_reg)
                    begin
                        ax_reg <= bx_reg;
                        ay_reg <= by_reg;
                        bx_reg <= first_tx_reg;
                        by_reg <= first_ty_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    assign vertex_valid = out_valid_reg;
    assign vertex_x     = out_x_reg;
    assign vertex_y     = out_y_reg;
    assign vertex_color = out_color_reg;
    assign end_of_run   = out_eor_reg;
    assign status       = out_status_reg;

    `PST_ASSERT_IMP(a_status_ends_run, vertex_valid && status, end_of_run && vertex_color == 32'd0, "status transaction must close its run with a zero vertex")
    `PST_ASSERT_NXT(a_busy_after_accept, point_valid && point_ready, !point_ready, "point taken while the previous one is still in work")
    `PST_ASSERT_IMP(a_unit_in_wait, iter_busy, state_reg == ST_SQRT || state_reg == ST_DIV, "root and divide unit running outside a wait state")

endmodule
